// ===== design/assert_macros.svh =====
// assertion macros used by the rtl top level
// no dependencies; assertions drop out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// implication checked in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");
// implication checked in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");
`else
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`define ASSERT_SAME(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/bqd_pkg.sv =====
// shared types and constants for the saturating biquad
// no dependencies
package bqd_pkg;

   localparam int SAMPLE_W           = 16;
   localparam int COEF_W             = 32;
   localparam int PROD_W             = COEF_W + SAMPLE_W;
   // five products summed: three guard bits
   localparam int ACC_W              = PROD_W + 3;
   localparam int CSR_INDEX_W        = 3;
   localparam int COEF_FRAC_BITS_DEF = 28;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ENABLE  = 3'd0,
      REG_COEF_B0 = 3'd1,
      REG_COEF_B1 = 3'd2,
      REG_COEF_B2 = 3'd3,
      REG_COEF_A1 = 3'd4,
      REG_COEF_A2 = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic                     enable;
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x1;
      logic signed [SAMPLE_W-1:0] x2;
      logic signed [SAMPLE_W-1:0] y1;
      logic signed [SAMPLE_W-1:0] y2;
   } hist_type;

endpackage

// ===== design/bqd_csr.sv =====
// configuration register file of the biquad
// depends on bqd_pkg
module bqd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bqd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bqd_pkg::COEF_W-1:0]       csr_data,
   output bqd_pkg::cfg_type                 cfg,
   output logic                             hist_clear
);

   bqd_pkg::cfg_type cfg_ff, cfg_in;
   logic             hit;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      hit    = 1'b0;
      if (csr_valid) begin
         hit = 1'b1;
         case (csr_index)
            bqd_pkg::REG_ENABLE:  cfg_in.enable = csr_data[0];
            bqd_pkg::REG_COEF_B0: cfg_in.b0     = csr_data;
            bqd_pkg::REG_COEF_B1: cfg_in.b1     = csr_data;
            bqd_pkg::REG_COEF_B2: cfg_in.b2     = csr_data;
            bqd_pkg::REG_COEF_A1: cfg_in.a1     = csr_data;
            bqd_pkg::REG_COEF_A2: cfg_in.a2     = csr_data;
            default:              hit           = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg        = cfg_ff;
   assign hist_clear = hit;

endmodule

// ===== design/bqd_datapath.sv =====
// multiply-accumulate, truncation toward zero and saturation for one sample
// depends on bqd_pkg
module bqd_datapath #(
   parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF
) (
   input  bqd_pkg::cfg_type                    cfg,
   input  bqd_pkg::hist_type                   hist,
   input  logic signed [bqd_pkg::SAMPLE_W-1:0] x,
   output logic signed [bqd_pkg::SAMPLE_W-1:0] y
);

   logic signed [bqd_pkg::PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
   logic signed [bqd_pkg::ACC_W-1:0]  acc;
   logic signed [bqd_pkg::ACC_W-1:0]  shifted;
   logic signed [bqd_pkg::ACC_W-1:0]  trunc;

   assign p_b0 = cfg.b0 * x;
   assign p_b1 = cfg.b1 * hist.x1;
   assign p_b2 = cfg.b2 * hist.x2;
   assign p_a1 = cfg.a1 * hist.y1;
   assign p_a2 = cfg.a2 * hist.y2;

   assign acc = bqd_pkg::ACC_W'(p_b0) + bqd_pkg::ACC_W'(p_b1) + bqd_pkg::ACC_W'(p_b2)
              + bqd_pkg::ACC_W'(p_a1) + bqd_pkg::ACC_W'(p_a2);

   assign shifted = acc >>> COEF_FRAC_BITS;

   always_comb begin
      // arithmetic shift floors; negative values with dropped bits step back up
      trunc = shifted;
      if (acc[bqd_pkg::ACC_W-1] && (acc[COEF_FRAC_BITS-1:0] != '0)) begin
         trunc = shifted + bqd_pkg::ACC_W'(1);
      end
      if (trunc > bqd_pkg::ACC_W'(bqd_pkg::SAMPLE_MAX)) begin
         y = bqd_pkg::SAMPLE_MAX;
      end else if (trunc < bqd_pkg::ACC_W'(bqd_pkg::SAMPLE_MIN)) begin
         y = bqd_pkg::SAMPLE_MIN;
      end else begin
         y = trunc[bqd_pkg::SAMPLE_W-1:0];
      end
   end

endmodule

// ===== design/biquad_iir_saturating.sv =====
// top level of the saturating direct form I biquad
// depends on bqd_pkg, bqd_csr, bqd_datapath and assert_macros.svh
//
// channel  direction  handshake        payload
// req      in         valid / stall    req_sample_in  (16 bit signed)
// rsp      out        valid / stall    rsp_sample_out (16 bit signed)
// csr      in         valid / ready    csr_index (3 bit), csr_data (32 bit)
//
// one sample per cycle sustained while rsp is not stalled; a sample goes from the
// input register to the result register, with the five multipliers, the adder
// and the saturation between them. the feedback through y1 closes within that one pass.
// synchronous active-high reset clears coefficients, enable and history;
// there is no clearing pass. a stalled result holds in the result register
// while the input register still takes one more beat.
`include "assert_macros.svh"

module biquad_iir_saturating #(
   parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [bqd_pkg::SAMPLE_W-1:0] req_sample_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [bqd_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bqd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bqd_pkg::COEF_W-1:0]          csr_data
);

   bqd_pkg::cfg_type  cfg;
   logic              hist_clear;

   // input register
   logic                                in_valid_ff, in_valid_in;
   logic signed [bqd_pkg::SAMPLE_W-1:0] in_sample_ff;

   // result register
   logic                                out_valid_ff, out_valid_in;
   logic signed [bqd_pkg::SAMPLE_W-1:0] out_sample_ff, out_sample_in;

   // filter history
   bqd_pkg::hist_type hist_ff, hist_in;

   logic                                req_take;
   logic                                out_free;
   logic                                fire;
   logic signed [bqd_pkg::SAMPLE_W-1:0] y_calc;

   bqd_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cfg        (cfg),
      .hist_clear (hist_clear)
   );

   bqd_datapath #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .cfg  (cfg),
      .hist (hist_ff),
      .x    (in_sample_ff),
      .y    (y_calc)
   );

   // result register is empty or is taken this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   // held sample moves into the result register
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end

      out_valid_in  = out_valid_ff;
      out_sample_in = out_sample_ff;
      if (fire) begin
         out_valid_in  = 1'b1;
         // disabled filter answers zero
         out_sample_in = cfg.enable ? y_calc : '0;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      hist_in = hist_ff;
      if (hist_clear) begin
         hist_in = '0;
      end else if (fire && cfg.enable) begin
         // shift both delay lines, disabled beats leave them untouched
         hist_in.x2 = hist_ff.x1;
         hist_in.x1 = in_sample_ff;
         hist_in.y2 = hist_ff.y1;
         hist_in.y1 = y_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         hist_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         hist_ff      <= hist_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_sample_ff <= req_sample_in;
      end
      out_sample_ff <= out_sample_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_sample_ff;

   // a disabled beat gives zero
   `ASSERT_NEXT(a_disabled_zero, clock, reset, fire && !cfg.enable, rsp_sample_out == '0)
   // a disabled beat keeps the history
   `ASSERT_NEXT(a_disabled_hold, clock, reset, fire && !cfg.enable && !hist_clear, $stable(hist_ff))
   // a write to a defined register empties the history
   `ASSERT_NEXT(a_clear_hist, clock, reset, hist_clear, hist_ff == '0)
   // newest output history matches the delivered result
   `ASSERT_NEXT(a_y1_tracks, clock, reset, fire && cfg.enable && !hist_clear, hist_ff.y1 == rsp_sample_out)

endmodule

// ===== sim/tb.sv =====
// self-checking testbench for biquad_iir_saturating: directed table, then random phases
// depends on bqd_pkg and the biquad_iir_saturating rtl; checked against a filter predictor
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC          = bqd_pkg::COEF_FRAC_BITS_DEF;
   localparam int RANDOM_ITEMS  = 900;
   // quiet time after draining, for margin
   localparam int SETTLE_CYCLES = 4;
   localparam int MAX_WAIT      = 11;

   // indexes past the last register, the block must drop these writes
   localparam logic [bqd_pkg::CSR_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [bqd_pkg::CSR_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

   // handy q3.28 coefficient values
   localparam logic [bqd_pkg::COEF_W-1:0] Q_ONE         = 32'h1000_0000;
   localparam logic [bqd_pkg::COEF_W-1:0] Q_HALF        = 32'h0800_0000;
   localparam logic [bqd_pkg::COEF_W-1:0] Q_NEG_ONE     = 32'hF000_0000;
   localparam logic [bqd_pkg::COEF_W-1:0] Q_NEG_QUARTER = 32'hFC00_0000;
   localparam logic [bqd_pkg::COEF_W-1:0] Q_MAX         = 32'h7FFF_FFFF;
   localparam logic [bqd_pkg::COEF_W-1:0] Q_MIN         = 32'h8000_0000;

   typedef enum bit {ROW_CSR, ROW_SAMPLE} row_kind_type;

   // one line of the directed table: a register write or a sample,
   // with the output typed in where it is obvious
   typedef struct {
      row_kind_type                        kind;
      logic [bqd_pkg::CSR_INDEX_W-1:0]     idx;
      logic [bqd_pkg::COEF_W-1:0]          data;
      logic signed [bqd_pkg::SAMPLE_W-1:0] x;
      bit                                  fixed;
      logic signed [bqd_pkg::SAMPLE_W-1:0] y;
   } stim_row_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic signed [bqd_pkg::SAMPLE_W-1:0] req_sample_in = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [bqd_pkg::SAMPLE_W-1:0] rsp_sample_out;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [bqd_pkg::CSR_INDEX_W-1:0]     csr_index = '0;
   logic [bqd_pkg::COEF_W-1:0]          csr_data = '0;

   // filter state as the block should hold it
   logic                                flt_enable = 1'b0;
   logic signed [bqd_pkg::COEF_W-1:0]   flt_b0 = '0;
   logic signed [bqd_pkg::COEF_W-1:0]   flt_b1 = '0;
   logic signed [bqd_pkg::COEF_W-1:0]   flt_b2 = '0;
   logic signed [bqd_pkg::COEF_W-1:0]   flt_a1 = '0;
   logic signed [bqd_pkg::COEF_W-1:0]   flt_a2 = '0;
   logic signed [bqd_pkg::SAMPLE_W-1:0] flt_x1 = '0;
   logic signed [bqd_pkg::SAMPLE_W-1:0] flt_x2 = '0;
   logic signed [bqd_pkg::SAMPLE_W-1:0] flt_y1 = '0;
   logic signed [bqd_pkg::SAMPLE_W-1:0] flt_y2 = '0;

   // filtered samples still owed by the block, oldest first
   logic signed [bqd_pkg::SAMPLE_W-1:0] pending_out_q[$];
   stim_row_type                        dir_rows[$];
   int unsigned                         fail_count = 0;
   bit                                  req_burst = 1'b0;
   bit                                  rsp_burst = 1'b0;

   biquad_iir_saturating dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #5 clock = ~clock;

   // one filter step: exact sum of five products, shift with truncation
   // toward zero, saturation, then both histories move along
   function automatic logic signed [bqd_pkg::SAMPLE_W-1:0] filter_next_out(
      input logic signed [bqd_pkg::SAMPLE_W-1:0] x);
      longint                              acc;
      longint                              mag;
      logic signed [bqd_pkg::SAMPLE_W-1:0] y;
      // disabled: zero out, history frozen
      if (!flt_enable) return '0;
      acc = longint'(flt_b0) * longint'(x)
          + longint'(flt_b1) * longint'(flt_x1)
          + longint'(flt_b2) * longint'(flt_x2)
          + longint'(flt_a1) * longint'(flt_y1)
          + longint'(flt_a2) * longint'(flt_y2);
      // shift the magnitude so negatives round toward zero
      mag = (acc < 0) ? -acc : acc;
      mag = mag >>> FRAC;
      if (acc < 0)
         y = (mag > -longint'(bqd_pkg::SAMPLE_MIN)) ? bqd_pkg::SAMPLE_MIN
                                                    : -mag[bqd_pkg::SAMPLE_W-1:0];
      else
         y = (mag > longint'(bqd_pkg::SAMPLE_MAX)) ? bqd_pkg::SAMPLE_MAX
                                                   : mag[bqd_pkg::SAMPLE_W-1:0];
      // the saturated value is what goes into the feedback history
      flt_x2 = flt_x1;
      flt_x1 = x;
      flt_y2 = flt_y1;
      flt_y1 = y;
      return y;
   endfunction

   // register write as the block sees it; any valid index wipes the history
   function automatic void filter_write_reg(input logic [bqd_pkg::CSR_INDEX_W-1:0] idx,
                                            input logic [bqd_pkg::COEF_W-1:0] data);
      case (idx)
         bqd_pkg::REG_ENABLE:  flt_enable = data[0];
         bqd_pkg::REG_COEF_B0: flt_b0 = data;
         bqd_pkg::REG_COEF_B1: flt_b1 = data;
         bqd_pkg::REG_COEF_B2: flt_b2 = data;
         bqd_pkg::REG_COEF_A1: flt_a1 = data;
         bqd_pkg::REG_COEF_A2: flt_a2 = data;
         default: return;
      endcase
      flt_x1 = '0;
      flt_x2 = '0;
      flt_y1 = '0;
      flt_y2 = '0;
   endfunction

   function automatic void add_csr(input logic [bqd_pkg::CSR_INDEX_W-1:0] idx,
                                   input logic [bqd_pkg::COEF_W-1:0] data);
      dir_rows.push_back('{kind: ROW_CSR, idx: idx, data: data, x: '0, fixed: 1'b0, y: '0});
   endfunction

   function automatic void add_sample(input logic signed [bqd_pkg::SAMPLE_W-1:0] x,
                                      input bit fixed,
                                      input logic signed [bqd_pkg::SAMPLE_W-1:0] y);
      dir_rows.push_back('{kind: ROW_SAMPLE, idx: '0, data: '0, x: x, fixed: fixed, y: y});
   endfunction

   // coefficient mix: extremes, unity, zero, full range and a band within +-1.0
   function automatic logic [bqd_pkg::COEF_W-1:0] pick_coef();
      case ($urandom_range(0, 7))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return '0;
         3: return $urandom();
         4: return Q_ONE;
         default: return $urandom_range(0, 2 * Q_ONE) - Q_ONE;
      endcase
   endfunction

   function automatic logic signed [bqd_pkg::SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return bqd_pkg::SAMPLE_MAX;
         1: return bqd_pkg::SAMPLE_MIN;
         2: return bqd_pkg::SAMPLE_W'($urandom_range(0, 600) - 300);
         default: return bqd_pkg::SAMPLE_W'($urandom());
      endcase
   endfunction

   // one input beat, after a random gap unless the sender is in a burst
   task automatic send_sample(input logic signed [bqd_pkg::SAMPLE_W-1:0] x,
                              input bit fixed,
                              input logic signed [bqd_pkg::SAMPLE_W-1:0] fixed_y);
      int                                  gap;
      logic signed [bqd_pkg::SAMPLE_W-1:0] y;
      gap = req_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= x;
      do @(posedge clock); while (req_stall !== 1'b0);
      // the predictor is always called, so its history follows the block
      y = filter_next_out(x);
      pending_out_q.push_back(fixed ? fixed_y : y);
   endtask

   // stop sending and let every owed result come out
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_out_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one config beat, then valid is held low before the next, so valid never drops and rises in one step
   task automatic csr_write(input logic [bqd_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [bqd_pkg::COEF_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      filter_write_reg(idx, data);
      @(posedge clock);
   endtask

   // new filter setting between phases; enable mostly on, with junk in the upper bits
   task automatic retune_filter(input bit all_regs);
      logic [bqd_pkg::COEF_W-1:0] data;
      drain_results();
      for (int r = bqd_pkg::REG_ENABLE; r <= bqd_pkg::REG_COEF_A2; r++) begin
         if (all_regs || $urandom_range(0, 1)) begin
            if (r == bqd_pkg::REG_ENABLE) begin
               data    = $urandom();
               data[0] = ($urandom_range(0, 6) != 0);
            end else begin
               data = pick_coef();
            end
            csr_write(r[bqd_pkg::CSR_INDEX_W-1:0], data);
         end
      end
   endtask

   // result side: a random stall before each beat, with stretches of none
   initial begin
      int hold;
      wait (reset == 1'b0);
      forever begin
         if ($urandom_range(0, 49) == 0) rsp_burst = !rsp_burst;
         hold = rsp_burst ? 0 : $urandom_range(0, MAX_WAIT);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
      end
   end

   // every accepted result beat against the oldest owed sample
   always @(posedge clock) begin
      logic signed [bqd_pkg::SAMPLE_W-1:0] want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_out_q.size() == 0) begin
            $error("sample_out: beat with nothing pending, actual %0d", rsp_sample_out);
            fail_count++;
         end else begin
            want = pending_out_q.pop_front();
            if (rsp_sample_out !== want) begin
               $error("sample_out mismatch: expected %0d, actual %0d", want, rsp_sample_out);
               fail_count++;
            end
         end
      end
   end

   // main sequence
   initial begin
      int n;
      int random_sent;
      bit first;

      // after reset: disabled, so zero out whatever comes in
      add_sample(bqd_pkg::SAMPLE_MAX, 1'b1, 16'sd0);
      add_sample(bqd_pkg::SAMPLE_MIN, 1'b1, 16'sd0);
      // enabled but all gains still zero
      add_csr(bqd_pkg::REG_ENABLE, 32'd1);
      add_sample(16'sd1234, 1'b1, 16'sd0);
      // unity gain passes both extremes, the negative one exactly at the edge
      add_csr(bqd_pkg::REG_COEF_B0, Q_ONE);
      add_sample(bqd_pkg::SAMPLE_MAX, 1'b1, bqd_pkg::SAMPLE_MAX);
      add_sample(bqd_pkg::SAMPLE_MIN, 1'b1, bqd_pkg::SAMPLE_MIN);
      add_sample(16'sd0, 1'b1, 16'sd0);
      // largest positive gain drives both rails
      add_csr(bqd_pkg::REG_COEF_B0, Q_MAX);
      add_sample(bqd_pkg::SAMPLE_MAX, 1'b1, bqd_pkg::SAMPLE_MAX);
      add_sample(bqd_pkg::SAMPLE_MIN, 1'b1, bqd_pkg::SAMPLE_MIN);
      // most negative gain flips the sign and still saturates
      add_csr(bqd_pkg::REG_COEF_B0, Q_MIN);
      add_sample(bqd_pkg::SAMPLE_MIN, 1'b1, bqd_pkg::SAMPLE_MAX);
      add_sample(bqd_pkg::SAMPLE_MAX, 1'b1, bqd_pkg::SAMPLE_MIN);
      // half gain: odd negatives must round toward zero
      add_csr(bqd_pkg::REG_COEF_B0, Q_HALF);
      add_sample(-16'sd3, 1'b1, -16'sd1);
      add_sample(16'sd3, 1'b1, 16'sd1);
      add_sample(-16'sd1, 1'b1, 16'sd0);
      // full biquad with feedback, from here the predictor decides
      add_csr(bqd_pkg::REG_COEF_B1, Q_ONE);
      add_csr(bqd_pkg::REG_COEF_B2, Q_NEG_ONE);
      add_csr(bqd_pkg::REG_COEF_A1, Q_HALF);
      add_csr(bqd_pkg::REG_COEF_A2, Q_NEG_QUARTER);
      add_sample(16'sd1000, 1'b0, '0);
      add_sample(-16'sd20000, 1'b0, '0);
      add_sample(bqd_pkg::SAMPLE_MAX, 1'b0, '0);
      add_sample(bqd_pkg::SAMPLE_MIN, 1'b0, '0);
      // writes to spare indexes are dropped and keep the history
      add_csr(REG_SPARE_6, 32'hDEAD_BEEF);
      add_sample(16'sd700, 1'b0, '0);
      add_csr(REG_SPARE_7, 32'hFFFF_FFFF);
      add_sample(-16'sd700, 1'b0, '0);
      // enable only looks at bit 0
      add_csr(bqd_pkg::REG_ENABLE, 32'hFFFF_FFFE);
      add_sample(16'sd5, 1'b1, 16'sd0);
      add_csr(bqd_pkg::REG_ENABLE, 32'h0000_0003);
      add_sample(16'sd12345, 1'b0, '0);
      add_sample(-16'sd321, 1'b0, '0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // registers only change with the block idle
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            drain_results();
            csr_write(dir_rows[i].idx, dir_rows[i].data);
         end else begin
            send_sample(dir_rows[i].x, dir_rows[i].fixed, dir_rows[i].y);
         end
      end

      // random phases, each with its own setting and sender pace
      random_sent = 0;
      first       = 1'b1;
      while (random_sent < RANDOM_ITEMS) begin
         retune_filter(first);
         first     = 1'b0;
         req_burst = ($urandom_range(0, 3) == 0);
         n         = $urandom_range(8, 60);
         repeat (n) begin
            // now and then hold off until the pipe is empty, sometimes
            // slipping in a dropped write that must leave the history alone
            if ($urandom_range(0, 39) == 0) drain_results();
            if ($urandom_range(0, 39) == 0) begin
               drain_results();
               csr_write($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom());
            end
            send_sample(pick_sample(), 1'b0, '0);
            random_sent++;
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("biquad_iir_saturating test passed");
      end else begin
         $display("biquad_iir_saturating test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #3ms;
      $display("biquad_iir_saturating test failed");
      $finish;
   end

endmodule
